@@ rtl/core/npc_pkg.sv @@
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants of the nearest palette color block.
// ----------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

  // Palette geometry and field widths
  localparam int unsigned PALETTE_DEPTH_DEFAULT = 256;
  localparam int unsigned CHAN_W                = 8;
  localparam int unsigned ENTRY_W               = 3 * CHAN_W;
  localparam int unsigned SIZE_W                = 9;
  localparam int unsigned INDEX_W               = 8;
  localparam int unsigned SQ_W                  = 2 * CHAN_W;
  localparam int unsigned DIST_W                = SQ_W + 2;
  localparam int unsigned BOUND_W               = DIST_W + 1;

  // Starting bound of the minimum search, above any reachable distance
  localparam logic [BOUND_W-1:0] DIST_BOUND = BOUND_W'(1 << 18);

  // Operation carried in tuser
  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/npc_ram.sv @@
// ----------------------------------------------------------------------------
// npc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_ram #(
  parameter int unsigned WIDTH  = 24,
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/nearest_palette_color_core.sv @@
// ----------------------------------------------------------------------------
// nearest_palette_color_core
// Maps an RGB888 color to the lowest palette index at minimum squared
// Euclidean distance. Load beats write palette entries; query beats scan.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tdata: index, r, g, b
//                                                 tuser: func
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata: palette_index
//   cfg       in   cfg_wen                        cfg_wdata: palette_size
//
// A load beat writes its entry as it is accepted and leaves s_axis_tready
// high. A query with N entries (palette size clamped to PALETTE_DEPTH, N > 0)
// scans all entries, then puts its result out; an empty palette skips the scan.
// The palette RAM read port yields one entry per cycle into a shared distance
// unit (square stage, then sum and compare). s_axis_tready is low while a
// query runs. The result sits in an output register, so the next beat is
// taken while it waits; a query that finishes while the output is still full
// holds until it drains.
// Reset (rst, synchronous) clears control and palette_size; the palette
// itself is undefined until written and has no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_core #(
  parameter int unsigned PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // entry_index[7:0], red[15:8],
                                          // green[23:16], blue[31:24]
  input  wire logic        s_axis_tuser,  // func[0]
  // Output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // palette_index[7:0]
  // Configuration
  input  wire logic        cfg_wen,
  input  wire logic [8:0]  cfg_wdata      // palette_size[8:0]
);

  localparam int unsigned ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(PALETTE_DEPTH + 1);
  localparam int unsigned CHAN_W = npc_pkg::CHAN_W;
  localparam int unsigned SQ_W   = npc_pkg::SQ_W;
  localparam int unsigned DIST_W = npc_pkg::DIST_W;
  localparam int unsigned BOUND_W = npc_pkg::BOUND_W;

  // Control and configuration
  npc_pkg::state_t               state;
  logic [npc_pkg::SIZE_W-1:0]    palette_size;
  logic [CNT_W-1:0]              scan_len;
  logic [CNT_W-1:0]              issue_cnt;

  // Query color
  logic [CHAN_W-1:0]             q_red, q_green, q_blue;

  // Read stage
  logic                          rd_vld, rd_last;
  logic [ADDR_W-1:0]             rd_idx;
  logic [npc_pkg::ENTRY_W-1:0]   rd_data;

  // Square stage
  logic                          sq_vld, sq_last;
  logic [ADDR_W-1:0]             sq_idx;
  logic [SQ_W-1:0]               sq_r, sq_g, sq_b;

  // Running minimum
  logic [BOUND_W-1:0]            best_dist;
  logic [ADDR_W-1:0]             best_idx;

  logic                          in_beat, is_query, is_load, wr_ok, issue;
  logic [CNT_W-1:0]              size_clamped;
  logic [CHAN_W-1:0]             d_r, d_g, d_b;
  logic [DIST_W-1:0]             sum_dist;
  logic                          closer, out_free;

  assign s_axis_tready = (state == npc_pkg::ST_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign is_query      = (npc_pkg::func_t'(s_axis_tuser) == npc_pkg::FUNC_QUERY);
  assign is_load       = !is_query;
  assign wr_ok         = ({1'b0, s_axis_tdata[7:0]} < 9'(PALETTE_DEPTH));
  assign size_clamped  = (palette_size > 9'(PALETTE_DEPTH)) ?
                         CNT_W'(PALETTE_DEPTH) : CNT_W'(palette_size);
  assign issue         = (state == npc_pkg::ST_SCAN) && (issue_cnt < scan_len);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  // Capture palette_size
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= '0;
    end else if (cfg_wen) begin
      palette_size <= cfg_wdata;
    end
  end

  // Palette storage
  npc_ram #(
    .WIDTH (npc_pkg::ENTRY_W),
    .DEPTH (PALETTE_DEPTH),
    .ADDR_W(ADDR_W)
  ) u_palette (
    .clk    (clk),
    .wr_en  (in_beat && is_load && wr_ok),
    .wr_addr(s_axis_tdata[ADDR_W-1:0]),
    .wr_data({s_axis_tdata[15:8], s_axis_tdata[23:16], s_axis_tdata[31:24]}),
    .rd_en  (issue),
    .rd_addr(issue_cnt[ADDR_W-1:0]),
    .rd_data(rd_data)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= npc_pkg::ST_IDLE;
    end else begin
      unique case (state)
        npc_pkg::ST_IDLE: begin
          if (in_beat && is_query) begin
            state <= (size_clamped == '0) ? npc_pkg::ST_DONE : npc_pkg::ST_SCAN;
          end
        end
        npc_pkg::ST_SCAN: begin
          if (sq_vld && sq_last) begin
            state <= npc_pkg::ST_DONE;
          end
        end
        npc_pkg::ST_DONE: begin
          if (out_free) begin
            state <= npc_pkg::ST_IDLE;
          end
        end
        default: state <= npc_pkg::ST_IDLE;
      endcase
    end
  end

  // Latch the query and advance the read address
  always_ff @(posedge clk) begin
    if (in_beat && is_query) begin
      q_red     <= s_axis_tdata[15:8];
      q_green   <= s_axis_tdata[23:16];
      q_blue    <= s_axis_tdata[31:24];
      scan_len  <= size_clamped;
      issue_cnt <= '0;
    end else if (issue) begin
      issue_cnt <= issue_cnt + CNT_W'(1);
    end
  end

  // Read stage tags
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx  <= issue_cnt[ADDR_W-1:0];
    rd_last <= (issue_cnt == scan_len - CNT_W'(1));
  end

  // Square stage: absolute differences, then squares
  assign d_r = (rd_data[23:16] > q_red)   ? rd_data[23:16] - q_red   : q_red   - rd_data[23:16];
  assign d_g = (rd_data[15:8]  > q_green) ? rd_data[15:8]  - q_green : q_green - rd_data[15:8];
  assign d_b = (rd_data[7:0]   > q_blue)  ? rd_data[7:0]   - q_blue  : q_blue  - rd_data[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= 1'b0;
    end else begin
      sq_vld <= rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    sq_idx  <= rd_idx;
    sq_last <= rd_last;
    sq_r    <= {{CHAN_W{1'b0}}, d_r} * {{CHAN_W{1'b0}}, d_r};
    sq_g    <= {{CHAN_W{1'b0}}, d_g} * {{CHAN_W{1'b0}}, d_g};
    sq_b    <= {{CHAN_W{1'b0}}, d_b} * {{CHAN_W{1'b0}}, d_b};
  end

  // Sum and compare: keep the first index at strictly smaller distance
  assign sum_dist = {2'b00, sq_r} + {2'b00, sq_g} + {2'b00, sq_b};
  assign closer   = ({1'b0, sum_dist} < best_dist);

  always_ff @(posedge clk) begin
    if (in_beat && is_query) begin
      best_dist <= npc_pkg::DIST_BOUND;
      best_idx  <= '0;
    end else if (sq_vld && closer) begin
      best_dist <= {1'b0, sum_dist};
      best_idx  <= sq_idx;
    end
  end

  // Output register: drop on take, load when the query finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if ((state == npc_pkg::ST_DONE) && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == npc_pkg::ST_DONE) && out_free) begin
      m_axis_tdata <= 8'(best_idx);
    end
  end

  // Checks
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == npc_pkg::ST_SCAN) |-> (issue_cnt <= scan_len))
    else $error("read address ran past the scan length");

  a_tag_in_range: assert property (@(posedge clk) disable iff (rst)
    sq_vld |-> (CNT_W'(sq_idx) < scan_len))
    else $error("distance evaluated for an entry outside the scan");

  a_last_ends_scan: assert property (@(posedge clk) disable iff (rst)
    ((state == npc_pkg::ST_SCAN) && sq_vld && sq_last) |=> (state == npc_pkg::ST_DONE))
    else $error("scan did not end after the last entry");

  a_empty_gives_zero: assert property (@(posedge clk) disable iff (rst)
    ((state == npc_pkg::ST_DONE) && (scan_len == '0)) |-> (best_idx == '0))
    else $error("empty palette did not give index zero");

  a_bound_held: assert property (@(posedge clk) disable iff (rst)
    (state == npc_pkg::ST_DONE) |-> (best_dist <= npc_pkg::DIST_BOUND))
    else $error("running minimum above its starting bound");

endmodule

`default_nettype wire
